FILE: rtl/core/gqlu_pkg.sv
package gqlu_pkg;

   // default grid size
   localparam int GRID_ROWS_DEF = 16;
   localparam int GRID_COLS_DEF = 16;

   // field widths
   localparam int Q_W        = 32;
   localparam int FRAC_W     = 12;
   localparam int REWARD_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int COORD_W    = 4;
   localparam int NEXT_W     = COORD_W + 1;
   localparam int MOVE_W     = 2;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int LANES      = 4;

   // datapath widths of the update
   localparam int PROD1_W = GAIN_W + 1 + Q_W;
   localparam int DELTA_W = 35;
   localparam int PROD2_W = GAIN_W + 1 + DELTA_W;
   localparam int SUM_W   = PROD2_W - GAIN_W + 2;

   // pending item queue, power of two
   localparam int QUEUE_DEPTH = 2;

   // rewards and thresholds
   localparam logic signed [REWARD_W-1:0] STEP_COST      = -16'sd10;
   localparam logic signed [REWARD_W-1:0] GOAL_REWARD    = 16'sd10000;
   localparam logic signed [Q_W-1:0]      GREEDY_FLOOR_Q = -32'sd40960000;
   localparam logic signed [Q_W-1:0]      EDGE_Q         = -32'sd409600;

   typedef enum logic [MODE_W-1:0] {
      MODE_OBST  = 2'd0,
      MODE_LEARN = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   typedef enum logic [MOVE_W-1:0] {
      MOVE_UP    = 2'd0,
      MOVE_DOWN  = 2'd1,
      MOVE_LEFT  = 2'd2,
      MOVE_RIGHT = 2'd3
   } move_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARN_RATE     = 3'd0,
      CSR_DISCOUNT       = 3'd1,
      CSR_GOAL_ROW       = 3'd2,
      CSR_GOAL_COL       = 3'd3,
      CSR_BLOCKED_REWARD = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      K_PASS  = 3'd0,
      K_OBST  = 3'd1,
      K_QUERY = 3'd2,
      K_HOLD  = 3'd3,
      K_LEARN = 3'd4
   } kind_type;

   typedef struct packed {
      logic [GAIN_W-1:0]          learn_rate;
      logic [GAIN_W-1:0]          discount;
      logic [COORD_W-1:0]         goal_row;
      logic [COORD_W-1:0]         goal_col;
      logic signed [REWARD_W-1:0] blocked_reward;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      learn_rate:     16'd6554,
      discount:       16'd58982,
      goal_row:       4'd15,
      goal_col:       4'd15,
      blocked_reward: -16'sd100
   };

   typedef struct packed {
      kind_type           kind;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [NEXT_W-1:0]  nrow;
      logic [NEXT_W-1:0]  ncol;
      move_type           move;
      logic               obit;
      logic               at_goal;
      logic               off_grid;
      logic               next_goal;
   } item_type;

   typedef struct packed {
      logic [COORD_W-1:0]         next_row;
      logic [COORD_W-1:0]         next_col;
      logic signed [REWARD_W-1:0] step_reward;
      logic signed [Q_W-1:0]      new_q;
      logic                       at_goal;
      logic                       off_grid;
      logic [MOVE_W-1:0]          best_move;
   } rsp_type;

endpackage

FILE: rtl/core/gqlu_front.sv
module gqlu_front
   import gqlu_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [COORD_W-1:0]  req_row,
   input  logic [COORD_W-1:0]  req_col,
   input  logic [MOVE_W-1:0]   req_move,
   input  logic                req_obstacle_bit,
   input  cfg_type             cfg,
   input  logic                queue_full,
   input  logic                clearing,
   output logic                push,
   output item_type            item
);

   logic              in_grid;
   logic              legal;
   logic [NEXT_W-1:0] step_row;
   logic [NEXT_W-1:0] step_col;

   // accept handshake
   assign busy = queue_full || clearing;
   assign push = start && !busy;

   assign in_grid = (32'(req_row) < GRID_ROWS) && (32'(req_col) < GRID_COLS);

   // neighbor cell and legality of the move
   always_comb begin
      step_row = NEXT_W'(req_row);
      step_col = NEXT_W'(req_col);
      legal    = 1'b1;
      unique case (move_type'(req_move))
         MOVE_UP: begin
            if (req_row == '0) legal = 1'b0;
            else step_row = NEXT_W'(req_row) - NEXT_W'(1);
         end
         MOVE_DOWN: begin
            if (32'(req_row) + 32'd1 >= GRID_ROWS) legal = 1'b0;
            else step_row = NEXT_W'(req_row) + NEXT_W'(1);
         end
         MOVE_LEFT: begin
            if (req_col == '0) legal = 1'b0;
            else step_col = NEXT_W'(req_col) - NEXT_W'(1);
         end
         MOVE_RIGHT: begin
            if (32'(req_col) + 32'd1 >= GRID_COLS) legal = 1'b0;
            else step_col = NEXT_W'(req_col) + NEXT_W'(1);
         end
      endcase
   end

   // classify the beat
   always_comb begin
      item.row       = req_row;
      item.col       = req_col;
      item.nrow      = NEXT_W'(req_row);
      item.ncol      = NEXT_W'(req_col);
      item.move      = move_type'(req_move);
      item.obit      = req_obstacle_bit;
      item.at_goal   = (req_row == cfg.goal_row) && (req_col == cfg.goal_col);
      item.off_grid  = 1'b0;
      item.kind      = K_PASS;
      if (!in_grid) begin
         item.off_grid = 1'b1;
      end else begin
         unique case (req_mode)
            MODE_OBST: item.kind = K_OBST;
            MODE_QUERY: item.kind = K_QUERY;
            MODE_LEARN: begin
               if (legal) begin
                  item.kind = K_LEARN;
                  item.nrow = step_row;
                  item.ncol = step_col;
               end else begin
                  item.kind     = K_HOLD;
                  item.off_grid = 1'b1;
               end
            end
            default: item.kind = K_PASS;
         endcase
      end
      item.next_goal = (item.nrow == {1'b0, cfg.goal_row}) &&
                       (item.ncol == {1'b0, cfg.goal_col});
   end

endmodule

FILE: rtl/core/gqlu_queue.sv
module gqlu_queue
   import gqlu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: rtl/core/gqlu_back.sv
module gqlu_back
   import gqlu_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     head_valid,
   input  item_type head_item,
   output logic     pop,
   output logic     clearing,
   output logic     rsp_valid,
   output rsp_type  rsp
);

   localparam int CELLS    = GRID_ROWS * GRID_COLS;
   localparam int CELL_W   = $clog2(CELLS);
   localparam int ROW_W    = $clog2(GRID_ROWS);
   localparam int COL_W    = $clog2(GRID_COLS);
   localparam int ROW_BITS = LANES * Q_W;

   typedef enum logic [6:0] {
      B_CLEAR = 7'b0000001,
      B_IDLE  = 7'b0000010,
      B_MAX   = 7'b0000100,
      B_MUL1  = 7'b0001000,
      B_DELTA = 7'b0010000,
      B_MUL2  = 7'b0100000,
      B_DONE  = 7'b1000000
   } state_type;

   function automatic logic [CELL_W-1:0] cell_of(input logic [NEXT_W-1:0] r,
                                                 input logic [NEXT_W-1:0] c);
      return CELL_W'(int'(r) * GRID_COLS + int'(c));
   endfunction

   // q store: one row of four move values per cell, plus obstacle bits
   logic [ROW_BITS-1:0] qmem [CELLS];
   logic                obst_mem [CELLS];

   state_type                  state_ff, state_in;
   logic [CELL_W-1:0]          clr_addr_ff, clr_addr_in;
   logic [ROW_W-1:0]           clr_row_ff, clr_row_in;
   logic [COL_W-1:0]           clr_col_ff, clr_col_in;
   item_type                   itm_ff;
   logic [CELL_W-1:0]          cur_addr_ff, cur_addr_in;
   logic [CELL_W-1:0]          nxt_addr_in;
   logic [ROW_BITS-1:0]        cur_row_ff, nxt_row_ff;
   logic                       obst_rd_ff;
   logic signed [Q_W-1:0]      cur_q [LANES];
   logic signed [Q_W-1:0]      nxt_q [LANES];
   logic [ROW_BITS-1:0]        clear_row_data;
   logic [ROW_BITS-1:0]        upd_row;
   move_type                   p01, p23, sel;
   logic signed [Q_W-1:0]      vmax;
   logic                       above_floor;
   logic signed [Q_W-1:0]      qmax_ff, qcur_ff, qbest_ff;
   logic [MOVE_W-1:0]          best_ff, best_in;
   logic signed [REWARD_W-1:0] reward_ff, reward_in;
   logic signed [PROD1_W-1:0]  prod1_ff, prod1_in;
   logic signed [DELTA_W-1:0]  delta_ff, delta_in;
   logic signed [PROD2_W-1:0]  prod2_ff, prod2_in;
   logic signed [SUM_W-1:0]    sum;
   logic                       ovf;
   logic signed [Q_W-1:0]      learn_q;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;

   assign clearing  = state_ff == B_CLEAR;
   assign pop       = (state_ff == B_IDLE) && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign cur_addr_in = cell_of(NEXT_W'(head_item.row), NEXT_W'(head_item.col));
   assign nxt_addr_in = cell_of(head_item.nrow, head_item.ncol);

   // control sequence
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: if (clr_addr_ff == CELL_W'(CELLS - 1)) state_in = B_IDLE;
         B_IDLE: begin
            if (head_valid) begin
               if (head_item.kind == K_PASS || head_item.kind == K_OBST) state_in = B_DONE;
               else state_in = B_MAX;
            end
         end
         B_MAX:   state_in = (itm_ff.kind == K_LEARN) ? B_MUL1 : B_DONE;
         B_MUL1:  state_in = B_DELTA;
         B_DELTA: state_in = B_MUL2;
         B_MUL2:  state_in = B_DONE;
         B_DONE:  state_in = B_IDLE;
         default: state_in = B_CLEAR;
      endcase
   end

   // clearing sweep counters
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_row_in  = clr_row_ff;
      clr_col_in  = clr_col_ff;
      if (state_ff == B_CLEAR) begin
         clr_addr_in = clr_addr_ff + CELL_W'(1);
         if (clr_col_ff == COL_W'(GRID_COLS - 1)) begin
            clr_col_in = '0;
            clr_row_in = clr_row_ff + ROW_W'(1);
         end else begin
            clr_col_in = clr_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         clr_row_ff   <= '0;
         clr_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_row_ff   <= clr_row_in;
         clr_col_ff   <= clr_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // reset contents of one cell: off-grid moves start at EDGE_Q, the others at zero
   always_comb begin
      clear_row_data = '0;
      if (clr_row_ff == '0) clear_row_data[0*Q_W +: Q_W] = EDGE_Q;
      if (clr_row_ff == ROW_W'(GRID_ROWS - 1)) clear_row_data[1*Q_W +: Q_W] = EDGE_Q;
      if (clr_col_ff == '0) clear_row_data[2*Q_W +: Q_W] = EDGE_Q;
      if (clr_col_ff == COL_W'(GRID_COLS - 1)) clear_row_data[3*Q_W +: Q_W] = EDGE_Q;
   end

   // lanes of the rows read out
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         cur_q[i] = cur_row_ff[i*Q_W +: Q_W];
         nxt_q[i] = nxt_row_ff[i*Q_W +: Q_W];
      end
   end

   // write side of the stores
   always_ff @(posedge clock) begin
      if (state_ff == B_CLEAR) begin
         qmem[clr_addr_ff]     <= clear_row_data;
         obst_mem[clr_addr_ff] <= 1'b0;
      end else if (state_ff == B_DONE) begin
         if (itm_ff.kind == K_LEARN) qmem[cur_addr_ff] <= upd_row;
         if (itm_ff.kind == K_OBST)  obst_mem[cur_addr_ff] <= itm_ff.obit;
      end
   end

   // read side: current row, next row and next obstacle bit
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_row_ff  <= qmem[cur_addr_in];
         nxt_row_ff  <= qmem[nxt_addr_in];
         obst_rd_ff  <= obst_mem[nxt_addr_in];
         itm_ff      <= head_item;
         cur_addr_ff <= cur_addr_in;
      end
   end

   // max of four lanes, lowest index on ties
   always_comb begin
      p01 = (nxt_q[1] > nxt_q[0]) ? MOVE_DOWN : MOVE_UP;
      p23 = (nxt_q[3] > nxt_q[2]) ? MOVE_RIGHT : MOVE_LEFT;
      sel = (nxt_q[p23] > nxt_q[p01]) ? p23 : p01;
      vmax = nxt_q[sel];
      above_floor = vmax > GREEDY_FLOOR_Q;
      best_in = above_floor ? MOVE_W'(sel) : MOVE_W'(MOVE_UP);
   end

   // reward of entering the next cell
   always_comb begin
      reward_in = STEP_COST;
      if (obst_rd_ff) reward_in = cfg.blocked_reward;
      if (itm_ff.next_goal) reward_in = GOAL_REWARD;
   end

   // arithmetic steps, each product registered
   assign prod1_in = $signed({1'b0, cfg.discount}) * qmax_ff;
   assign delta_in = (DELTA_W'(reward_ff) <<< FRAC_W) + DELTA_W'(prod1_ff >>> GAIN_W)
                     - DELTA_W'(qcur_ff);
   assign prod2_in = $signed({1'b0, cfg.learn_rate}) * delta_ff;

   always_ff @(posedge clock) begin
      if (state_ff == B_MAX) begin
         qmax_ff   <= vmax;
         qbest_ff  <= above_floor ? vmax : nxt_q[0];
         best_ff   <= best_in;
         qcur_ff   <= cur_q[itm_ff.move];
         reward_ff <= reward_in;
      end
      if (state_ff == B_MUL1)  prod1_ff <= prod1_in;
      if (state_ff == B_DELTA) delta_ff <= delta_in;
      if (state_ff == B_MUL2)  prod2_ff <= prod2_in;
   end

   // saturating accumulate and row merge
   always_comb begin
      sum = SUM_W'(qcur_ff) + SUM_W'(prod2_ff >>> GAIN_W);
      ovf = sum[SUM_W-1:Q_W-1] != {(SUM_W-Q_W+1){sum[SUM_W-1]}};
      if (!ovf) learn_q = sum[Q_W-1:0];
      else if (sum[SUM_W-1]) learn_q = {1'b1, {(Q_W-1){1'b0}}};
      else learn_q = {1'b0, {(Q_W-1){1'b1}}};
      upd_row = cur_row_ff;
      upd_row[itm_ff.move*Q_W +: Q_W] = learn_q;
   end

   // result beat
   always_comb begin
      rsp_valid_in       = state_ff == B_DONE;
      rsp_in.next_row    = itm_ff.nrow[COORD_W-1:0];
      rsp_in.next_col    = itm_ff.ncol[COORD_W-1:0];
      rsp_in.at_goal     = itm_ff.at_goal;
      rsp_in.off_grid    = itm_ff.off_grid;
      rsp_in.step_reward = '0;
      rsp_in.new_q       = '0;
      rsp_in.best_move   = '0;
      case (itm_ff.kind)
         K_LEARN: begin
            rsp_in.step_reward = reward_ff;
            rsp_in.new_q       = learn_q;
         end
         K_HOLD: rsp_in.new_q = qcur_ff;
         K_QUERY: begin
            rsp_in.new_q     = qbest_ff;
            rsp_in.best_move = best_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_DONE) rsp_ff <= rsp_in;
   end

   // checks
   a_done_gives_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DONE |=> rsp_valid_ff)
      else $error("finished item gave no result beat");

   a_beat_is_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result beat held longer than one cycle");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_CLEAR |-> !rsp_valid_ff && !pop)
      else $error("activity during clearing sweep");

   a_off_no_reward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.off_grid |-> rsp_ff.step_reward == '0)
      else $error("off-grid result carries a reward");

endmodule

FILE: rtl/core/grid_q_learning_update.sv
// learning step: queue, B_IDLE, B_MAX, B_MUL1, B_DELTA, B_MUL2, B_DONE, then the result
// strobe; greedy query or illegal move: B_IDLE, B_MAX, B_DONE; obstacle write, off-grid
// cell or unused mode: B_IDLE, B_DONE; the back end runs one item at a time (q row read,
// 4-way max, two multiplies, write-back); a 2-entry queue lets a new item in while the back
// end works; busy is high when it is full and, after reset, while the q and obstacle stores
// are swept to their initial contents; registers take reset values at once; no output stall
module grid_q_learning_update
   import gqlu_pkg::*;
#(
   parameter int GRID_ROWS = GRID_ROWS_DEF,
   parameter int GRID_COLS = GRID_COLS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [COORD_W-1:0]         req_row,
   input  logic [COORD_W-1:0]         req_col,
   input  logic [MOVE_W-1:0]          req_move,
   input  logic                       req_obstacle_bit,
   output logic                       rsp_valid,
   output logic [COORD_W-1:0]         rsp_next_row,
   output logic [COORD_W-1:0]         rsp_next_col,
   output logic signed [REWARD_W-1:0] rsp_step_reward,
   output logic signed [Q_W-1:0]      rsp_new_q,
   output logic                       rsp_at_goal,
   output logic                       rsp_off_grid,
   output logic [MOVE_W-1:0]          rsp_best_move,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     push;
   item_type push_item;
   logic     queue_full;
   logic     head_valid;
   item_type head_item;
   logic     pop;
   logic     clearing;
   rsp_type  rsp;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LEARN_RATE:     cfg_in.learn_rate     = csr_data;
            CSR_DISCOUNT:       cfg_in.discount       = csr_data;
            CSR_GOAL_ROW:       cfg_in.goal_row       = csr_data[COORD_W-1:0];
            CSR_GOAL_COL:       cfg_in.goal_col       = csr_data[COORD_W-1:0];
            CSR_BLOCKED_REWARD: cfg_in.blocked_reward = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CFG_RESET;
      else cfg_ff <= cfg_in;
   end

   gqlu_front #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_front (
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_move         (req_move),
      .req_obstacle_bit (req_obstacle_bit),
      .cfg              (cfg_ff),
      .queue_full       (queue_full),
      .clearing         (clearing),
      .push             (push),
      .item             (push_item)
   );

   gqlu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   gqlu_back #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   // result fields
   assign rsp_next_row    = rsp.next_row;
   assign rsp_next_col    = rsp.next_col;
   assign rsp_step_reward = rsp.step_reward;
   assign rsp_new_q       = rsp.new_q;
   assign rsp_at_goal     = rsp.at_goal;
   assign rsp_off_grid    = rsp.off_grid;
   assign rsp_best_move   = rsp.best_move;

endmodule
